// File: rtl/crou_pkg.sv
// ----------------------------------------------------------------------------
// crou_pkg: shared types for the Cholesky rank-one update core
// Word layout, decoded work-kind codes and the queue head struct.
// ----------------------------------------------------------------------------
package crou_pkg;

    localparam int IDX_W     = 6;
    localparam int DATA_W    = 32;
    localparam int S_TDATA_W = 48;
    localparam int WORK_DEPTH = 64;

    typedef enum logic [1:0] {
        OP_LOAD_V = 2'd0,
        OP_FACTOR = 2'd1,
        OP_LOAD_Y = 2'd2,
        OP_Z      = 2'd3
    } op_t;

    // decoded kind of a queued word
    typedef enum logic [1:0] {
        K_LOAD = 2'd0,
        K_DIAG = 2'd1,
        K_OFFD = 2'd2,
        K_ZEL  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                    kind;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [DATA_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

endpackage

// File: rtl/crou_front.sv
// ----------------------------------------------------------------------------
// crou_front: input side
// Takes stream words, decodes them and queues work for the back end.
// ----------------------------------------------------------------------------
module crou_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // operation[1:0], row[7:2], col[13:8], value[45:14], zero pad
    input  logic [crou_pkg::S_TDATA_W-1:0]   s_tdata,
    output crou_pkg::head_t                  head,
    input  logic                             pop
);

    crou_pkg::item_t ent_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      cnt_reg, cnt_next;

    crou_pkg::item_t in_item;
    logic            keep;
    logic            push;

    always_comb
    begin
        in_item.row   = s_tdata[7:2];
        in_item.col   = s_tdata[13:8];
        in_item.value = s_tdata[45:14];
        in_item.kind  = crou_pkg::K_LOAD;
        keep          = 1'b1;
        unique case (crou_pkg::op_t'(s_tdata[1:0]))
            crou_pkg::OP_LOAD_V, crou_pkg::OP_LOAD_Y:
                in_item.kind = crou_pkg::K_LOAD;
            crou_pkg::OP_FACTOR:
            begin
                if (s_tdata[7:2] == s_tdata[13:8])
                    in_item.kind = crou_pkg::K_DIAG;
                else
                    in_item.kind = crou_pkg::K_OFFD;
                // above the diagonal: dropped here
                keep = (s_tdata[7:2] >= s_tdata[13:8]);
            end
            crou_pkg::OP_Z:
                in_item.kind = crou_pkg::K_ZEL;
            default:
                in_item.kind = crou_pkg::K_LOAD;
        endcase
    end

    assign s_tready   = (cnt_reg != 2'd2);
    assign push       = s_tvalid && s_tready && keep;
    assign head.valid = (cnt_reg != 2'd0);
    assign head.item  = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_ptr_reg] <= in_item;
    end

endmodule

// File: rtl/crou_back.sv
// ----------------------------------------------------------------------------
// crou_back: execution side
// Work store, rotation tables, shared multiplier, sqrt and divide sequencer.
// ----------------------------------------------------------------------------
module crou_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  crou_pkg::head_t               head,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // result_value[31:0]
    output logic [crou_pkg::DATA_W-1:0]   m_tdata,
    // status[0]
    output logic                          m_tuser
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_READ = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_SQRT = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    localparam logic [63:0] SQ_TOP = 64'h4000_0000_0000_0000;
    localparam logic [31:0] R_MAX  = 32'h7FFF_FFFF;

    logic signed [31:0] work_mem [crou_pkg::WORK_DEPTH];
    logic signed [31:0] cos_mem  [crou_pkg::WORK_DEPTH];
    logic signed [31:0] sin_mem  [crou_pkg::WORK_DEPTH];

    state_t state_reg, state_next;
    logic   err_reg, err_next;
    logic   out_valid_reg, out_valid_next;
    logic   dv_sel_reg, dv_sel_next;

    crou_pkg::item_t    it_reg, it_next;
    logic signed [31:0] work_rd_reg, cos_rd_reg, sin_rd_reg;
    logic [2:0]         mc_reg, mc_next;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [63:0] acc0_reg, acc0_next;
    logic signed [63:0] acc1_reg, acc1_next;
    logic [63:0]        sq_v_reg, sq_v_next;
    logic [63:0]        sq_res_reg, sq_res_next;
    logic [63:0]        sq_bit_reg, sq_bit_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [31:0]        r_reg, r_next;
    logic [47:0]        dv_num_reg, dv_num_next;
    logic [31:0]        dv_rem_reg, dv_rem_next;
    logic [47:0]        dv_q_reg, dv_q_next;
    logic [31:0]        res_reg, res_next;
    logic               res_stat_reg, res_stat_next;
    logic [31:0]        out_data_reg, out_data_next;
    logic               out_stat_reg, out_stat_next;

    logic [crou_pkg::IDX_W-1:0] rd_row, rd_col;
    logic                       work_we, cos_we, sin_we;
    logic [crou_pkg::IDX_W-1:0] work_wa;
    logic signed [31:0]         work_wd, cs_wd;
    logic signed [31:0]         opa, opb;
    logic [63:0]                sq_sum;
    logic [32:0]                rem_sh;
    logic signed [31:0]         dv_a;
    logic [31:0]                dv_mag;
    logic [31:0]                q_lo;

    // round Q32.32 to Q16.16 (add half, floor), then saturate
    function automatic logic [31:0] round_sat(input logic signed [63:0] v);
        logic signed [63:0] t;
        logic signed [47:0] f;
        begin
            t = v + 64'sd32768;
            f = t[63:16];
            if (f > 48'sh0000_7FFF_FFFF)
                round_sat = 32'h7FFF_FFFF;
            else if (f < -48'sh0000_8000_0000)
                round_sat = 32'h8000_0000;
            else
                round_sat = f[31:0];
        end
    endfunction

    assign rd_row = (state_reg == S_IDLE) ? head.item.row : it_reg.row;
    assign rd_col = (state_reg == S_IDLE) ? head.item.col : it_reg.col;

    assign sq_sum = sq_res_reg + sq_bit_reg;
    assign rem_sh = {dv_rem_reg, dv_num_reg[47]};
    assign dv_a   = dv_sel_reg ? work_rd_reg : it_reg.value;
    assign dv_mag = dv_a[31] ? (32'd0 - dv_a) : dv_a;
    assign q_lo   = dv_q_reg[31:0];

    always_comb
    begin
        opa = it_reg.value;
        opb = it_reg.value;
        if (it_reg.kind == crou_pkg::K_DIAG)
        begin
            opa = (mc_reg == 3'd0) ? it_reg.value : work_rd_reg;
            opb = opa;
        end
        else
        begin
            unique case (mc_reg[1:0])
                2'd0: begin opa = cos_rd_reg; opb = it_reg.value; end
                2'd1: begin opa = sin_rd_reg; opb = work_rd_reg;  end
                2'd2: begin opa = cos_rd_reg; opb = work_rd_reg;  end
                2'd3: begin opa = sin_rd_reg; opb = it_reg.value; end
                default: begin opa = cos_rd_reg; opb = it_reg.value; end
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        err_next       = err_reg;
        dv_sel_next    = dv_sel_reg;
        it_next        = it_reg;
        mc_next        = mc_reg;
        prod_next      = prod_reg;
        acc0_next      = acc0_reg;
        acc1_next      = acc1_reg;
        sq_v_next      = sq_v_reg;
        sq_res_next    = sq_res_reg;
        sq_bit_next    = sq_bit_reg;
        cnt_next       = cnt_reg;
        r_next         = r_reg;
        dv_num_next    = dv_num_reg;
        dv_rem_next    = dv_rem_reg;
        dv_q_next      = dv_q_reg;
        res_next       = res_reg;
        res_stat_next  = res_stat_reg;
        out_data_next  = out_data_reg;
        out_stat_next  = out_stat_reg;
        out_valid_next = out_valid_reg && !m_tready;
        pop            = 1'b0;
        work_we        = 1'b0;
        work_wa        = it_reg.row;
        work_wd        = it_reg.value;
        cos_we         = 1'b0;
        sin_we         = 1'b0;
        cs_wd          = dv_a[31] ? (32'd0 - q_lo) : q_lo;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop     = 1'b1;
                    it_next = head.item;
                    if (head.item.kind == crou_pkg::K_LOAD)
                    begin
                        work_we = 1'b1;
                        work_wa = head.item.row;
                        work_wd = head.item.value;
                    end
                    else
                        state_next = S_READ;
                end
            end
            S_READ:
            begin
                mc_next = 3'd0;
                if (err_reg)
                begin
                    res_next      = it_reg.value;
                    res_stat_next = 1'b1;
                    state_next    = S_OUT;
                end
                else if (it_reg.kind == crou_pkg::K_DIAG &&
                         it_reg.value == 32'sd0 && work_rd_reg == 32'sd0)
                begin
                    err_next      = 1'b1;
                    res_next      = it_reg.value;
                    res_stat_next = 1'b1;
                    state_next    = S_OUT;
                end
                else
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next = opa * opb;
                mc_next   = mc_reg + 3'd1;
                unique case (mc_reg)
                    3'd1: acc0_next = prod_reg;
                    3'd2: acc0_next = acc0_reg + prod_reg;
                    3'd3: acc1_next = prod_reg;
                    3'd4: acc1_next = acc1_reg - prod_reg;
                    default: acc0_next = acc0_reg;
                endcase
                if (it_reg.kind == crou_pkg::K_DIAG && mc_reg == 3'd2)
                begin
                    sq_v_next   = acc0_reg + prod_reg;
                    sq_res_next = 64'd0;
                    sq_bit_next = SQ_TOP;
                    cnt_next    = 6'd0;
                    state_next  = S_SQRT;
                end
                else if (it_reg.kind != crou_pkg::K_DIAG && mc_reg == 3'd4)
                    state_next = S_FIN;
            end
            S_SQRT:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd32)
                begin
                    // round to nearest
                    r_next      = (sq_v_reg > sq_res_reg) ? sq_res_reg[31:0] + 32'd1
                                                          : sq_res_reg[31:0];
                    cnt_next    = 6'd0;
                    dv_sel_next = 1'b0;
                    state_next  = S_DIV;
                end
                else
                begin
                    if (sq_v_reg >= sq_sum)
                    begin
                        sq_v_next   = sq_v_reg - sq_sum;
                        sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
                    end
                    else
                        sq_res_next = sq_res_reg >> 1;
                    sq_bit_next = sq_bit_reg >> 2;
                end
            end
            S_DIV:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    dv_num_next = {dv_mag, 16'd0} + {17'd0, r_reg[31:1]};
                    dv_rem_next = 32'd0;
                    dv_q_next   = 48'd0;
                end
                else if (cnt_reg <= 6'd48)
                begin
                    dv_num_next = {dv_num_reg[46:0], 1'b0};
                    if (rem_sh >= {1'b0, r_reg})
                    begin
                        dv_rem_next = 32'(rem_sh - {1'b0, r_reg});
                        dv_q_next   = {dv_q_reg[46:0], 1'b1};
                    end
                    else
                    begin
                        dv_rem_next = rem_sh[31:0];
                        dv_q_next   = {dv_q_reg[46:0], 1'b0};
                    end
                end
                else
                begin
                    cnt_next = 6'd0;
                    if (!dv_sel_reg)
                    begin
                        cos_we      = 1'b1;
                        dv_sel_next = 1'b1;
                    end
                    else
                    begin
                        sin_we        = 1'b1;
                        res_next      = (r_reg > R_MAX) ? R_MAX : r_reg;
                        res_stat_next = 1'b0;
                        state_next    = S_OUT;
                    end
                end
            end
            S_FIN:
            begin
                work_we       = 1'b1;
                work_wa       = it_reg.row;
                work_wd       = round_sat(acc1_reg);
                res_next      = round_sat(acc0_reg);
                res_stat_next = 1'b0;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    out_stat_next  = res_stat_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dv_sel_reg   <= dv_sel_next;
        it_reg       <= it_next;
        mc_reg       <= mc_next;
        prod_reg     <= prod_next;
        acc0_reg     <= acc0_next;
        acc1_reg     <= acc1_next;
        sq_v_reg     <= sq_v_next;
        sq_res_reg   <= sq_res_next;
        sq_bit_reg   <= sq_bit_next;
        cnt_reg      <= cnt_next;
        r_reg        <= r_next;
        dv_num_reg   <= dv_num_next;
        dv_rem_reg   <= dv_rem_next;
        dv_q_reg     <= dv_q_next;
        res_reg      <= res_next;
        res_stat_reg <= res_stat_next;
        out_data_reg <= out_data_next;
        out_stat_reg <= out_stat_next;
    end

    // work store and rotation tables, registered reads
    always_ff @(posedge clk)
    begin
        if (work_we)
            work_mem[work_wa] <= work_wd;
        if (cos_we)
            cos_mem[it_reg.col] <= cs_wd;
        if (sin_we)
            sin_mem[it_reg.col] <= cs_wd;
        work_rd_reg <= work_mem[rd_row];
        cos_rd_reg  <= cos_mem[rd_col];
        sin_rd_reg  <= sin_mem[rd_col];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_stat_reg;

endmodule

// File: rtl/cholesky_rank_one_update_core.sv
// Back end: a load word is written to the work store straight from idle; an
// off-diagonal/Z word goes through the shared multiplier to a result; a diagonal
// word runs the sqrt and then two divides (cos, then sin). The back end handles
// one word at a time in its sequencer; a 2-deep queue lets the front take words meanwhile.
// Reset: rst_n async active low clears queue, sequencer, output and error flag;
// work store and rotation tables are not cleared.
// ----------------------------------------------------------------------------
// cholesky_rank_one_update_core: Givens rank-one update of a lower factor
// Front decodes and queues words; back runs rotations in Q16.16.
// ----------------------------------------------------------------------------
module cholesky_rank_one_update_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // operation[1:0], row[7:2], col[13:8], value[45:14], zero pad [47:46]
    input  logic [crou_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // result_value[31:0]
    output logic [crou_pkg::DATA_W-1:0]     m_tdata,
    // status[0]: sticky numerical error
    output logic                            m_tuser
);

    crou_pkg::head_t head;
    logic            pop;

    // decode and queue; words above the diagonal are dropped here
    crou_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .head     (head),
        .pop      (pop)
    );

    // execution with output register
    crou_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: sim/cholesky_rank_one_update_core_tb.sv
// ----------------------------------------------------------------------------
// cholesky_rank_one_update_core_tb: self-checking bench for the rank-one core
// Drives v/y loads, factor and Z words over the input stream, predicts each
// rotated element in Q16.16 and checks the output stream word by word.
// ----------------------------------------------------------------------------
module cholesky_rank_one_update_core_tb;

    localparam int WDOG_LIMIT = 20000;

    typedef struct {
        logic [31:0] value;
        logic        status;
    } elem_exp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    // predictor state
    longint      work_mem [64];
    longint      cos_tab [64];
    longint      sin_tab [64];
    bit          err_sticky;
    bit          work_ok [64];
    bit          rot_ok [64];

    elem_exp_t   elem_q [$];
    int          snd_idle = 0;
    int          rcv_idle = 0;
    int          hold_left = 0;
    int          n_words = 0;
    int          n_elems = 0;
    int          n_fail = 0;
    int          wdog = 0;

    cholesky_rank_one_update_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Q32.32 -> Q16.16, round half up (floor of v + 1/2)
    function automatic longint to_q16(longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic longint unsigned root_nearest(longint unsigned v);
        longint unsigned res;
        longint unsigned b4;
        res = 0;
        b4 = 64'h4000_0000_0000_0000;
        while (b4 > v)
            b4 = b4 >> 2;
        while (b4 != 0)
        begin
            if (v >= res + b4)
            begin
                v = v - (res + b4);
                res = (res >> 1) + b4;
            end
            else
                res = res >> 1;
            b4 = b4 >> 2;
        end
        if (v > res)
            res++;
        return res;
    endfunction

    function automatic longint unsigned magn(longint a);
        return (a < 0) ? longint'(-a) : a;
    endfunction

    // a / r in Q16.16, nearest, ties away from zero
    function automatic longint quot_q16(longint a, longint unsigned r);
        longint unsigned q;
        q = ((magn(a) << 16) + r / 2) / r;
        return (a < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Givens rotation of x against work entry idx; returns the new element
    function automatic longint givens_apply(int c, int idx, longint x);
        longint nx;
        longint nw;
        nx = clamp32(to_q16(cos_tab[c] * x + sin_tab[c] * work_mem[idx]));
        nw = clamp32(to_q16(cos_tab[c] * work_mem[idx] - sin_tab[c] * x));
        work_mem[idx] = nw;
        return nx;
    endfunction

    // update the mirror state for one accepted word, queue its element if any
    task automatic apply_word(crou_pkg::op_t op, int row, int col, logic [31:0] raw);
        longint x;
        longint b;
        longint res;
        longint unsigned r;
        x = longint'($signed(raw));
        if (op == crou_pkg::OP_LOAD_V || op == crou_pkg::OP_LOAD_Y)
        begin
            work_mem[row] = x;
            work_ok[row] = 1'b1;
            return;
        end
        if (op == crou_pkg::OP_FACTOR && row < col)
            return;                             // upper triangle: dropped
        if (err_sticky)
            res = x;
        else if (op == crou_pkg::OP_FACTOR && row == col)
        begin
            b = work_mem[col];
            if (x == 0 && b == 0)
            begin
                err_sticky = 1'b1;
                res = x;
            end
            else
            begin
                r = root_nearest(magn(x) * magn(x) + magn(b) * magn(b));
                cos_tab[col] = quot_q16(x, r);
                sin_tab[col] = quot_q16(b, r);
                rot_ok[col] = 1'b1;
                res = (r > 64'h7FFF_FFFF) ? 64'sd2147483647 : longint'(r);
            end
        end
        else
            res = givens_apply(col, row, x);
        elem_q.push_back('{value: res[31:0], status: err_sticky});
    endtask

    // offer one word, hold it until taken, then predict
    task automatic send_word(crou_pkg::op_t op, int row, int col, logic [31:0] val);
        while ($urandom_range(99) < snd_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, val, 6'(col), 6'(row), op};
        do
            @(posedge clk);
        while (!s_tready);
        n_words++;
        apply_word(op, row, col, val);
    endtask

    task automatic go_quiet();
        s_tvalid <= 1'b0;
        while (elem_q.size() != 0)
            @(posedge clk);
        repeat (160) @(posedge clk);           // a diagonal word may still be busy
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3, 4, 5: return $urandom;
            default: return 32'($signed($urandom_range(32'h40000)) -
                                $signed(32'h20000));
        endcase
    endfunction

    // never let a diagonal hit the both-zero case in normal traffic
    function automatic logic [31:0] safe_diag(int col, logic [31:0] v);
        if (v == 0 && work_mem[col] == 0)
            return 32'h0001_0000;
        return v;
    endfunction

    // checker: oldest expectation against every taken result
    always @(posedge clk)
    begin
        elem_exp_t e;
        if (m_tvalid && m_tready)
        begin
            n_elems++;
            if (elem_q.size() == 0)
            begin
                $error("unexpected result value=%h status=%b", m_tdata, m_tuser);
                n_fail++;
            end
            else
            begin
                e = elem_q.pop_front();
                if (m_tdata !== e.value)
                begin
                    $error("result_value exp %h got %h", e.value, m_tdata);
                    n_fail++;
                end
                if (m_tuser !== e.status)
                begin
                    $error("status exp %b got %b", e.status, m_tuser);
                    n_fail++;
                end
            end
        end
    end

    // receiver: random stalls, or a counted hold-off
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= rcv_idle);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            wdog <= 0;
        else if (wdog >= WDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            wdog <= wdog + 1;
    end

    // field extremes, negative and zero values on the diagonal, top indexes, ignored words
    task automatic test_directed_edges();
        send_word(crou_pkg::OP_LOAD_V, 0, 63, 32'h0);
        send_word(crou_pkg::OP_LOAD_V, 1, 0, 32'h7FFF_FFFF);
        send_word(crou_pkg::OP_LOAD_V, 63, 21, 32'h8000_0000);
        send_word(crou_pkg::OP_LOAD_V, 2, 42, 32'h0001_8000);
        send_word(crou_pkg::OP_FACTOR, 0, 0, 32'hFFFE_0000);    // b = 0, a < 0
        send_word(crou_pkg::OP_FACTOR, 1, 0, 32'h7FFF_FFFF);
        send_word(crou_pkg::OP_FACTOR, 63, 0, 32'h8000_0000);
        send_word(crou_pkg::OP_FACTOR, 2, 0, 32'h0000_0001);
        send_word(crou_pkg::OP_FACTOR, 0, 63, 32'h1234_5678);   // above diagonal
        send_word(crou_pkg::OP_FACTOR, 62, 63, 32'hFFFF_FFFF);  // above diagonal
        send_word(crou_pkg::OP_FACTOR, 63, 63, 32'h8000_0000);  // huge r, saturates
        send_word(crou_pkg::OP_FACTOR, 1, 1, 32'h0);            // a = 0, b != 0
        send_word(crou_pkg::OP_FACTOR, 2, 1, 32'h8000_0000);
        send_word(crou_pkg::OP_FACTOR, 63, 1, 32'h7FFF_FFFF);
        send_word(crou_pkg::OP_LOAD_Y, 63, 63, 32'h7FFF_FFFF);
        send_word(crou_pkg::OP_LOAD_Y, 0, 0, 32'h8000_0000);
        send_word(crou_pkg::OP_Z, 63, 63, 32'h8000_0000);
        send_word(crou_pkg::OP_Z, 0, 0, 32'h7FFF_FFFF);
        send_word(crou_pkg::OP_Z, 63, 1, 32'h0);
        send_word(crou_pkg::OP_Z, 0, 63, 32'hAAAA_5555);
        go_quiet();
    endtask

    // one update pass: v loads, factor in column order, y loads, Z words
    task automatic run_update_pass();
        int n;
        int base;
        int m;
        int rr;
        int zc;
        n = ($urandom_range(7) == 0) ? $urandom_range(7, 10) : $urandom_range(2, 5);
        base = $urandom_range(64 - n);
        for (int i = 0; i < n; i++)
            send_word(crou_pkg::OP_LOAD_V, base + i, $urandom_range(63), pick_value());
        for (int j = 0; j < n; j++)
        begin
            send_word(crou_pkg::OP_FACTOR, base + j, base + j,
                      safe_diag(base + j, pick_value()));
            for (int i = j + 1; i < n; i++)
                send_word(crou_pkg::OP_FACTOR, base + i, base + j, pick_value());
            // stray upper word, only where a column above exists
            if (base + j < 63 && $urandom_range(3) == 0)
                send_word(crou_pkg::OP_FACTOR, $urandom_range(base + j),
                          base + j + 1 + $urandom_range(62 - base - j),
                          $urandom);
        end
        m = $urandom_range(4);
        for (int k = 0; k < m; k++)
        begin
            rr = $urandom_range(63);
            send_word(crou_pkg::OP_LOAD_Y, rr, $urandom_range(63), pick_value());
            for (int j = 0; j < n; j++)
                send_word(crou_pkg::OP_Z, rr, base + j, pick_value());
        end
        // noise: a Z word on any column already rotated
        zc = $urandom_range(63);
        if (rot_ok[zc] && work_ok[zc])
            send_word(crou_pkg::OP_Z, zc, zc, $urandom);
    endtask

    task automatic test_random_updates();
        int stop_at;
        int snd_pct [3] = '{19, 53, 0};
        int rcv_pct [3] = '{53, 19, 0};
        for (int mode = 0; mode < 3; mode++)
        begin
            snd_idle = snd_pct[mode];
            rcv_idle = rcv_pct[mode];
            stop_at = n_words + 200;
            while (n_words < stop_at)
                run_update_pass();
            go_quiet();                              // sender waits for all results
        end
    endtask

    // receiver holds off long while off-diagonal words keep coming
    task automatic test_backpressure();
        snd_idle = 0;
        rcv_idle = 0;
        for (int i = 0; i < 4; i++)
            send_word(crou_pkg::OP_LOAD_V, 40 + i, 0, pick_value());
        send_word(crou_pkg::OP_FACTOR, 40, 40, safe_diag(40, pick_value()));
        go_quiet();
        hold_left = 400;
        for (int k = 0; k < 24; k++)
            send_word(crou_pkg::OP_FACTOR, 41 + (k % 3), 40, pick_value());
        go_quiet();
    endtask

    // both-zero diagonal sets the sticky flag, later elements pass through
    task automatic test_sticky_error();
        rcv_idle = 30;
        snd_idle = 30;
        send_word(crou_pkg::OP_LOAD_V, 7, 0, 32'h0);
        send_word(crou_pkg::OP_LOAD_V, 8, 0, 32'h0003_0000);
        send_word(crou_pkg::OP_FACTOR, 7, 7, 32'h0);
        send_word(crou_pkg::OP_FACTOR, 8, 7, 32'h1111_2222);
        send_word(crou_pkg::OP_FACTOR, 8, 8, 32'h8000_0000);
        send_word(crou_pkg::OP_FACTOR, 3, 8, 32'h5555_5555);    // still ignored
        send_word(crou_pkg::OP_LOAD_Y, 9, 0, 32'h0002_0000);
        send_word(crou_pkg::OP_Z, 9, 7, 32'h7FFF_FFFF);
        send_word(crou_pkg::OP_Z, 8, 8, 32'h0);
        s_tvalid <= 1'b0;
    endtask

    initial
    begin
        err_sticky = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_edges();
        test_random_updates();
        test_backpressure();
        test_sticky_error();
        while (elem_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("covered %0d words in, %0d elements out: loads, diagonals, rotations,",
                 n_words, n_elems);
        $display("Z drag, upper-triangle drops, saturation, long stall, sticky error");
        if (n_fail == 0 && elem_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
